### rtl/core/assert_macros.svh
// Assertion helpers. Bodies compile away when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset.
`define BLS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bls assertion failed");
// Checked on every rising edge, reset included.
`define BLS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bls assertion failed");
`else
`define BLS_ASSERT(lbl, clk, rst_n, prop)
`define BLS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/core/bls_pkg.sv
package bls_pkg;

  localparam int VAL_W = 32;
  localparam int CAP_W = 7;
  localparam int POS_W = 7;

  typedef logic [1:0] op_t;
  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP  = 2'd1;
  localparam op_t OP_PEEK = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STS_OK       = 2'd0;
  localparam status_t STS_OVERFLOW = 2'd1;
  localparam status_t STS_EMPTY    = 2'd2;
  localparam status_t STS_BEYOND   = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;  // item accepted: memory access, count update
    logic load;  // result goes into the output register
  } cmd_t;

endpackage

### rtl/core/bls_in_if.sv
interface bls_in_if
  import bls_pkg::*;
;
  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic signed [VAL_W-1:0] push_value;
  logic [POS_W-1:0]        peek_position;

  modport source (output valid, output operation, output push_value,
                  output peek_position, input ready);
  modport sink   (input valid, input operation, input push_value,
                  input peek_position, output ready);
endinterface

### rtl/core/bls_out_if.sv
interface bls_out_if
  import bls_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  status_t                 status;
  logic                    is_empty;
  logic                    is_full;
  logic [CAP_W-1:0]        element_count;

  modport source (output valid, output read_value, output status, output is_empty,
                  output is_full, output element_count, input ready);
  modport sink   (input valid, input read_value, input status, input is_empty,
                  input is_full, input element_count, output ready);
endinterface

### rtl/core/bls_cfg_if.sv
interface bls_cfg_if
  import bls_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

### rtl/core/bls_ctrl.sv
`include "assert_macros.svh"

module bls_ctrl
  import bls_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        // output slot free or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `BLS_ASSERT(a_accept_then_result, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_RESULT))
  `BLS_ASSERT(a_free_slot_loads, clk, rst_n, (state_r == S_RESULT && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
  `BLS_ASSERT(a_no_exec_and_load, clk, rst_n, !(cmd.exec && cmd.load))

endmodule

### rtl/core/bls_dp.sv
`include "assert_macros.svh"

module bls_dp
  import bls_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  op_t                     operation,
  input  logic signed [VAL_W-1:0] push_value,
  input  logic [POS_W-1:0]        peek_position,
  input  logic                    cfg_valid,
  input  logic [CAP_W-1:0]        cfg_capacity,
  output logic signed [VAL_W-1:0] read_value,
  output status_t                 status,
  output logic                    is_empty,
  output logic                    is_full,
  output logic [CAP_W-1:0]        element_count
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAX_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CMP_W  = (MAX_W > POS_W) ? MAX_W : POS_W;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CAP_W-1:0]        capacity_r;
  status_t                 sts_r, sts_nxt;
  logic                    rd_ok_r, rd_ok_nxt;

  logic signed [VAL_W-1:0] read_value_r;
  status_t                 status_r;
  logic                    is_empty_r, is_full_r;
  logic [CAP_W-1:0]        element_count_r;

  logic [CMP_W-1:0]  count_ext, below_ext, top_ext, peek_ext;
  logic [POS_W-1:0]  below;
  logic [ADDR_W-1:0] addr;
  logic              wr_en, full, empty;

  always_comb begin
    count_ext = CMP_W'(count_r);
    empty     = (count_r == '0);
    full      = (count_ext >= CMP_W'(capacity_r)) || (count_ext >= CMP_W'(DEPTH));
    below     = (peek_position == '0) ? '0 : peek_position - 1'b1;
    below_ext = CMP_W'(below);
    top_ext   = count_ext - 1'b1;
    peek_ext  = top_ext - below_ext;

    addr      = count_ext[ADDR_W-1:0];
    wr_en     = 1'b0;
    count_nxt = count_r;
    sts_nxt   = STS_OK;
    rd_ok_nxt = 1'b0;
    case (operation)
      OP_PUSH: begin
        if (full) begin
          sts_nxt = STS_OVERFLOW;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP: begin
        addr = top_ext[ADDR_W-1:0];
        if (empty) begin
          sts_nxt = STS_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          rd_ok_nxt = 1'b1;
        end
      end
      OP_PEEK: begin
        addr = peek_ext[ADDR_W-1:0];
        if (empty) begin
          sts_nxt = STS_EMPTY;
        end else if (below_ext >= count_ext) begin
          sts_nxt = STS_BEYOND;
        end else begin
          rd_ok_nxt = 1'b1;
        end
      end
      default: begin
        sts_nxt = STS_OK;
      end
    endcase
  end

  // single-port store
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) begin
        mem[addr] <= push_value;
      end
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      capacity_r <= CAP_W'(DEPTH);
    end else begin
      if (cmd.exec) begin
        count_r <= count_nxt;
      end
      if (cfg_valid) begin
        capacity_r <= cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      sts_r   <= sts_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
    if (cmd.load) begin
      read_value_r    <= rd_ok_r ? rd_data_r : '0;
      status_r        <= sts_r;
      is_empty_r      <= empty;
      is_full_r       <= full;
      element_count_r <= count_ext[CAP_W-1:0];
    end
  end

  assign read_value    = read_value_r;
  assign status        = status_r;
  assign is_empty      = is_empty_r;
  assign is_full       = is_full_r;
  assign element_count = element_count_r;

  `BLS_ASSERT_ALWAYS(a_count_bounded, clk, (count_r <= CNT_W'(DEPTH)) || !rst_n)
  `BLS_ASSERT(a_push_grows, clk, rst_n, (cmd.exec && operation == OP_PUSH && !full) |=> (count_r == $past(count_r) + 1'b1))
  `BLS_ASSERT(a_bad_status_no_read, clk, rst_n, (cmd.exec && sts_nxt != STS_OK) |=> !rd_ok_r)

endmodule

### rtl/core/bounded_lifo_stack_core.sv
// Bounded LIFO stack of signed 32-bit words with push, pop and peek. Each item
// on in_ch carries an operation (push, pop, peek, or the unused code which does
// nothing), and gives exactly one result on out_ch with read data, a status
// (ok, overflow, empty, beyond depth) and the empty/full flags and element count
// after the operation. cfg_ch writes the capacity; values above DEPTH act as
// DEPTH, zero makes every push overflow, and lowering it below the current
// count keeps the words held. Write it only while the block is idle. The block
// takes no new item until the result of the last one is loaded. The accept
// cycle does the single access to the single-port stack memory (write on push,
// registered read on pop/peek); once the output register is free or draining,
// the result moves into it. That output register lets the next item be
// accepted while a result waits on out_ch; if it is still occupied when a new
// result is ready, the block holds in_ch.ready low until out_ch drains. No
// clearing pass after reset: the count alone says which entries are live.
module bounded_lifo_stack_core
  import bls_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  bls_in_if.sink    in_ch,
  bls_out_if.source out_ch,
  bls_cfg_if.sink   cfg_ch
);

  cmd_t cmd;

  // capacity register takes a write every cycle
  assign cfg_ch.ready = 1'b1;

  // sequencing: accept, then result into output register
  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // store, count, capacity and result registers
  bls_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .operation     (in_ch.operation),
    .push_value    (in_ch.push_value),
    .peek_position (in_ch.peek_position),
    .cfg_valid     (cfg_ch.valid),
    .cfg_capacity  (cfg_ch.capacity),
    .read_value    (out_ch.read_value),
    .status        (out_ch.status),
    .is_empty      (out_ch.is_empty),
    .is_full       (out_ch.is_full),
    .element_count (out_ch.element_count)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bls_pkg::*;

  localparam int     STACK_DEPTH     = 64;
  localparam op_t    OP_NONE         = 2'd3;   // unused code, ignored by the block
  localparam int     HOLD_CYCLES     = 300;
  localparam int     SETTLE_CYCLES   = 4;
  localparam int     DRAIN_CYCLES    = 12;
  localparam int     MAX_REPORTS     = 10;
  localparam int     ITEMS_PER_PHASE = 66;
  localparam int     PUSH_HEAVY_N    = 36;
  localparam longint TIMEOUT_NS      = 4_000_000;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    status_t                 status;
    logic                    is_empty;
    logic                    is_full;
    logic [CAP_W-1:0]        element_count;
  } stack_result_t;

  // receiver behavior, picked at random per stretch
  typedef enum int {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_t;

  logic clk;
  logic rst_n;

  bls_in_if  in_ch ();
  bls_out_if out_ch ();
  bls_cfg_if cfg_ch ();

  bounded_lifo_stack_core #(
    .DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // shadow copy of the stack
  logic signed [VAL_W-1:0] shadow_words [STACK_DEPTH];
  int unsigned             shadow_count;
  logic [CAP_W-1:0]        shadow_capacity;

  stack_result_t expected_results [$];
  int            mismatch_count;
  int            burst_left;
  int            hold_left;   // long receiver hold-off, counted down by the receiver

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Shadow stack: update state for one accepted item, queue the result it gives.
  task automatic predict_stack_op(op_t op, logic signed [VAL_W-1:0] word,
                                  logic [POS_W-1:0] pos);
    stack_result_t r;
    int unsigned   cap;
    int unsigned   below;
    // capacity above the physical depth acts as the depth
    cap   = (shadow_capacity > STACK_DEPTH) ? STACK_DEPTH : shadow_capacity;
    r     = '0;
    below = (pos == 0) ? 0 : pos - 1;   // positions 0 and 1 are both the top
    case (op)
      OP_PUSH: begin
        // full also covers capacity zero and capacity lowered below the count
        if (shadow_count >= cap) begin
          r.status = STS_OVERFLOW;
        end else begin
          shadow_words[shadow_count] = word;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.status = STS_EMPTY;
        end else begin
          shadow_count--;
          r.read_value = shadow_words[shadow_count];
        end
      end
      OP_PEEK: begin
        // empty wins over beyond-depth
        if (shadow_count == 0) begin
          r.status = STS_EMPTY;
        end else if (below >= shadow_count) begin
          r.status = STS_BEYOND;
        end else begin
          r.read_value = shadow_words[shadow_count - 1 - below];
        end
      end
      default: begin
        // ignored code: ok status, zero data, state untouched
      end
    endcase
    r.is_empty      = (shadow_count == 0);
    r.is_full       = (shadow_count >= cap);
    r.element_count = CAP_W'(shadow_count);
    expected_results.push_back(r);
  endtask

  // Offer one item; bursts of random length separated by random gaps.
  // Returns at the edge where the item was taken, valid still high.
  task automatic send_item(op_t op, logic signed [VAL_W-1:0] word,
                           logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.push_value    <= word;
    in_ch.peek_position <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_stack_op(op, word, pos);
    burst_left--;
  endtask

  // Capacity write, only with the block idle and every result drained.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= cap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    shadow_capacity = cap;
    cfg_ch.valid    <= 1'b0;
  endtask

  // Receiver: random stretches of streaming, coin-flip, sparse and toggling
  // ready, plus the long hold-off when a test asks for it.
  initial begin
    rx_mode_t mode;
    int       span_left;
    out_ch.ready = 1'b0;
    span_left    = 0;
    mode         = RX_STREAM;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        if (span_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          span_left = $urandom_range(5, 60);
        end
        span_left--;
        case (mode)
          RX_STREAM: out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
          default:   out_ch.ready <= ~out_ch.ready;
        endcase
      end
    end
  end

  // Each result taken is compared with the oldest expectation.
  always @(posedge clk) begin
    stack_result_t got;
    stack_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.read_value    = out_ch.read_value;
      got.status        = out_ch.status;
      got.is_empty      = out_ch.is_empty;
      got.is_full       = out_ch.is_full;
      got.element_count = out_ch.element_count;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result data=%0d status=%0d empty=%0b full=%0b count=%0d",
                   $realtime, got.read_value, got.status, got.is_empty, got.is_full,
                   got.element_count);
      end else begin
        want = expected_results.pop_front();
        if (got.read_value !== want.read_value || got.status !== want.status ||
            got.is_empty !== want.is_empty || got.is_full !== want.is_full ||
            got.element_count !== want.element_count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch exp data=%0d status=%0d empty=%0b full=%0b count=%0d",
                     $realtime, want.read_value, want.status, want.is_empty, want.is_full,
                     want.element_count);
            $display("%0t:          got data=%0d status=%0d empty=%0b full=%0b count=%0d",
                     $realtime, got.read_value, got.status, got.is_empty, got.is_full,
                     got.element_count);
          end
        end
      end
    end
  end

  // Edge cases: empty stack, word extremes, every peek position class,
  // ignored code, capacity zero and capacity lowered under the count.
  task automatic test_directed_cases();
    send_item(OP_POP,  32'sd0, 7'd0);
    send_item(OP_PEEK, 32'sd0, 7'd5);      // empty beats beyond-depth
    send_item(OP_NONE, 32'sd0, 7'd0);
    send_item(OP_PUSH, 32'sh7FFF_FFFF, 7'd0);
    send_item(OP_PUSH, 32'sh8000_0000, 7'd0);
    send_item(OP_PUSH, -32'sd1, 7'd0);
    send_item(OP_PUSH, 32'sd0, 7'd0);
    send_item(OP_PEEK, 32'sd0, 7'd0);
    send_item(OP_PEEK, 32'sd0, 7'd1);
    send_item(OP_PEEK, 32'sd0, 7'd2);
    send_item(OP_PEEK, 32'sd0, 7'd4);      // bottom word
    send_item(OP_PEEK, 32'sd0, 7'd5);      // one past the bottom
    send_item(OP_PEEK, -32'sd1, 7'd127);
    send_item(OP_NONE, -32'sd1, 7'd127);
    repeat (5) send_item(OP_POP, 32'sd0, 7'd0);   // last one hits empty

    write_capacity(7'd0);
    send_item(OP_PUSH, 32'sd5, 7'd0);       // capacity zero: always overflows
    send_item(OP_PEEK, 32'sd0, 7'd1);
    send_item(OP_POP,  32'sd0, 7'd0);

    write_capacity(7'd2);
    repeat (3) send_item(OP_PUSH, $urandom(), 7'd0);
    write_capacity(7'd1);                   // now below the count of two
    send_item(OP_PUSH, $urandom(), 7'd0);
    send_item(OP_PEEK, 32'sd0, 7'd2);
    send_item(OP_POP,  32'sd0, 7'd0);
    send_item(OP_PUSH, $urandom(), 7'd0);   // count 1 == capacity 1, still full
    send_item(OP_POP,  32'sd0, 7'd0);
    send_item(OP_POP,  32'sd0, 7'd0);
  endtask

  // Capacity above depth clamps to depth: fill completely, probe, drain.
  task automatic test_fill_to_depth();
    write_capacity(7'd127);
    repeat (STACK_DEPTH) send_item(OP_PUSH, $urandom(), 7'd0);
    send_item(OP_PUSH, $urandom(), 7'd0);
    send_item(OP_PEEK, 32'sd0, 7'd64);
    send_item(OP_PEEK, 32'sd0, 7'd65);
    send_item(OP_PEEK, 32'sd0, 7'd0);
    repeat (STACK_DEPTH + 1) send_item(OP_POP, 32'sd0, 7'd0);
  endtask

  // Receiver stalls for a long stretch while items keep coming, so the
  // block has to hold its input off.
  task automatic test_output_backpressure();
    write_capacity(7'd64);
    hold_left = HOLD_CYCLES;
    repeat (30) send_item(OP_PUSH, $urandom(), 7'd0);
    repeat (10) send_item(OP_PEEK, 32'sd0, 7'($urandom_range(0, 32)));
    repeat (31) send_item(OP_POP, 32'sd0, 7'd0);
  endtask

  // Random phases under assorted capacities; each phase first leans on
  // pushes to build depth, then on pops and peeks to dig back down.
  task automatic test_random_traffic();
    logic [CAP_W-1:0] cap;
    op_t              op;
    logic [POS_W-1:0] pos;
    int               push_weight;
    int               roll;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       cap = 7'd64;
        1:       cap = 7'd127;
        2:       cap = 7'd0;
        3:       cap = 7'd1;
        4:       cap = 7'($urandom_range(2, 63));
        default: cap = 7'($urandom_range(0, 127));
      endcase
      write_capacity(cap);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        push_weight = (n < PUSH_HEAVY_N) ? 65 : 30;
        roll        = $urandom_range(0, 99);
        if (roll < 5)                     op = OP_NONE;
        else if (roll < 5 + push_weight)  op = OP_PUSH;
        else if (roll[0])                 op = OP_POP;
        else                              op = OP_PEEK;
        // peeks mostly land inside the stack or just past its bottom
        if (shadow_count > 0 && $urandom_range(0, 4) != 0)
          pos = 7'($urandom_range(0, shadow_count + 1));
        else
          pos = 7'($urandom_range(0, 127));
        send_item(op, $urandom(), pos);
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_PUSH;
    in_ch.push_value    = '0;
    in_ch.peek_position = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.capacity     = '0;
    mismatch_count      = 0;
    burst_left          = 0;
    hold_left           = 0;
    shadow_count        = 0;
    shadow_capacity     = CAP_W'(STACK_DEPTH);
    foreach (shadow_words[i]) shadow_words[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_fill_to_depth();
    test_output_backpressure();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/bls_pkg.sv
rtl/core/bls_in_if.sv
rtl/core/bls_out_if.sv
rtl/core/bls_cfg_if.sv
rtl/core/bls_ctrl.sv
rtl/core/bls_dp.sv
rtl/core/bounded_lifo_stack_core.sv
tb/testbench.sv
